### hdl/blpt_pkg.sv
// Shared types, codes, command/status structs and reset constants of the pose trajectory block.
package blpt_pkg;

    // Default parameter values.
    localparam int AXES_DEF      = 6;
    localparam int FRAC_BITS_DEF = 16;

    // Width of the shared divider: dividend bits and divisor bits.
    localparam int DIV_NW = 44;
    localparam int DIV_DW = 31;

    // Duration limits in milliseconds and the point spacing.
    localparam int DUR_MIN   = 1000;
    localparam int DUR_MAX   = 10000;
    localparam int PT_MS     = 20;
    localparam int PROG_ONE  = 65536;

    // The point count is the duration over four times one fifth in Q0.15; exact up to 10000 ms.
    localparam int PT_RECIP  = 6554;
    localparam int PT_SHIFT  = 15;

    // Item function codes carried in the input tuser.
    localparam logic [1:0] FN_LOAD_BOUND = 2'd0;
    localparam logic [1:0] FN_LOAD_AXIS  = 2'd1;
    localparam logic [1:0] FN_PLAN       = 2'd2;
    localparam logic [1:0] FN_TICK       = 2'd3;

    // Status codes of a status result.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_START_OOB = 2'd1;
    localparam logic [1:0] ST_TGT_OOB   = 2'd2;
    localparam logic [1:0] ST_NO_TRAJ   = 2'd3;

    // Result kinds carried in the output tuser.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_POINT  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_SQ,
        S_ROOT,
        S_DUR_GO,
        S_DUR_WAIT,
        S_COMMIT,
        S_STATUS,
        S_TICK,
        S_IDX_GO,
        S_IDX_WAIT,
        S_PROG_GO,
        S_PROG_WAIT,
        S_AX_GO,
        S_AX_WAIT,
        S_AX_EMIT
    } t_state;

    // Which quantity the shared divider is working on.
    typedef enum logic [2:0] {
        DS_DUR,
        DS_IDX,
        DS_PROG,
        DS_AXIS
    } t_div_sel;

    typedef struct packed {
        logic       capture;
        logic       step_idx;
        logic       sq_acc;
        logic       root_start;
        logic       div_start;
        t_div_sel   div_sel;
        logic       commit;
        logic       emit_status;
        logic [1:0] status_code;
        logic       emit_point;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic sq_last;
        logic phase;
        logic chk_fail;
        logic root_done;
        logic div_done;
        logic out_free;
        logic plan_ok;
    } t_dp_stat;

    // Value t/10 in fixed point with fb fraction bits, rounded.
    function automatic logic signed [31:0] tenths(input int t, input int fb);
        longint v;
        v = (longint'(t) * (longint'(1) << fb) + 5) / 10;
        return v[31:0];
    endfunction

    // Bound of an axis after reset.
    function automatic logic signed [31:0] def_bound(input int ax, input logic is_max,
                                                     input int fb);
        int t;
        logic signed [31:0] v;
        case (ax)
            0:       t = is_max ? 5 : 0;
            1, 2:    t = 5;
            3:       t = 21;
            4, 5:    t = 13;
            default: t = 0;
        endcase
        v = tenths(t, fb);
        if (!is_max) begin
            v = -v;
        end
        return v;
    endfunction

endpackage

### hdl/bounded_linear_pose_trajectory.sv
// Top level of the bounded linear pose trajectory generator.
//
// Load items (bounds, staged start/target) are stored on capture and give no
// result. A plan item checks the staged pose against the bounds one axis a
// cycle, sums the xyz squares, takes a digit-by-digit square root and one
// division on the shared divider for the duration; the point count follows
// from a reciprocal multiply, and the plan ends in one status beat. A tick
// item uses the same divider for the index, the progress and one step per
// axis, with one setpoint beat per axis; a tick before a valid plan returns
// one status beat. A new item is taken while the last result beat still
// waits. No beat and no velocity write is taken while reset is held.
module bounded_linear_pose_trajectory #(
    parameter int AXES      = blpt_pkg::AXES_DEF,
    parameter int FRAC_BITS = blpt_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [30:0]  i_cfg_data,      // velocity
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // axis[2:0], bound_select[3], bound_value[35:4], start_value[67:36],
    // target_value[99:68], target_gripper[107:100], elapsed_ms[123:108],
    // resetting[124], zero fill
    input  logic [127:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,    // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], axis_out[4:2], position[36:5], gripper_cmd[45:37],
    // progress[62:46], zero fill
    output logic [63:0]  m_axis_tdata,
    output logic         m_axis_tuser,    // kind
    output logic         m_axis_tlast
);
    blpt_pkg::t_dp_cmd  w_cmd;
    blpt_pkg::t_dp_stat w_stat;

    assign o_cfg_ready = i_rst_n;

    blpt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    blpt_datapath #(
        .AXES      (AXES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_func      (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_kind      (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule

### hdl/blpt_div.sv
// Shared restoring divider, one quotient bit per cycle.
module blpt_div #(
    parameter int NW = blpt_pkg::DIV_NW,
    parameter int DW = blpt_pkg::DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [NW-1:0] o_quot,
    output logic [DW-1:0] o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW-1:0] r_r;
    logic [DW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_trial;
    logic          w_ge;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign w_trial = {r_r, r_q[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[NW-2:0], w_ge};
            r_r <= w_ge ? DW'(w_trial - {1'b0, r_d}) : w_trial[DW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

### hdl/blpt_ctrl.sv
// Sequencing state machine for load, plan and tick items.
module blpt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [1:0]         s_axis_tuser,
    input  blpt_pkg::t_dp_stat i_stat,
    output blpt_pkg::t_dp_cmd  o_cmd
);
    blpt_pkg::t_state r_state, n_state;
    logic [1:0]       r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blpt_pkg::S_IDLE;
            r_code  <= blpt_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.div_sel     = blpt_pkg::DS_DUR;
        o_cmd.status_code = r_code;
        s_axis_tready = 1'b0;
        unique case (r_state)
            blpt_pkg::S_IDLE: begin
                // No beat is taken while reset is held.
                s_axis_tready = i_rst_n;
                if (s_axis_tvalid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    if (s_axis_tuser == blpt_pkg::FN_PLAN) begin
                        n_state = blpt_pkg::S_CHECK;
                    end else if (s_axis_tuser == blpt_pkg::FN_TICK) begin
                        n_state = blpt_pkg::S_TICK;
                    end
                end
            end
            blpt_pkg::S_CHECK: begin
                if (i_stat.chk_fail) begin
                    n_code  = i_stat.phase ? blpt_pkg::ST_TGT_OOB : blpt_pkg::ST_START_OOB;
                    n_state = blpt_pkg::S_STATUS;
                end else begin
                    o_cmd.step_idx = 1'b1;
                    if (i_stat.idx_last && i_stat.phase) begin
                        n_state = blpt_pkg::S_SQ;
                    end
                end
            end
            blpt_pkg::S_SQ: begin
                o_cmd.sq_acc   = 1'b1;
                o_cmd.step_idx = 1'b1;
                if (i_stat.sq_last) begin
                    n_state = blpt_pkg::S_ROOT;
                end
            end
            blpt_pkg::S_ROOT: begin
                // The root is started on entry and runs until it reports done.
                if (i_stat.root_done) begin
                    n_state = blpt_pkg::S_DUR_GO;
                end
            end
            blpt_pkg::S_DUR_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = blpt_pkg::DS_DUR;
                n_state         = blpt_pkg::S_DUR_WAIT;
            end
            blpt_pkg::S_DUR_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = blpt_pkg::S_COMMIT;
                end
            end
            blpt_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_code       = blpt_pkg::ST_OK;
                n_state      = blpt_pkg::S_STATUS;
            end
            blpt_pkg::S_STATUS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state           = blpt_pkg::S_IDLE;
                end
            end
            blpt_pkg::S_TICK: begin
                if (i_stat.plan_ok) begin
                    n_state = blpt_pkg::S_IDX_GO;
                end else begin
                    n_code  = blpt_pkg::ST_NO_TRAJ;
                    n_state = blpt_pkg::S_STATUS;
                end
            end
            blpt_pkg::S_IDX_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = blpt_pkg::DS_IDX;
                n_state         = blpt_pkg::S_IDX_WAIT;
            end
            blpt_pkg::S_IDX_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = blpt_pkg::S_PROG_GO;
                end
            end
            blpt_pkg::S_PROG_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = blpt_pkg::DS_PROG;
                n_state         = blpt_pkg::S_PROG_WAIT;
            end
            blpt_pkg::S_PROG_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = blpt_pkg::S_AX_GO;
                end
            end
            blpt_pkg::S_AX_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = blpt_pkg::DS_AXIS;
                n_state         = blpt_pkg::S_AX_WAIT;
            end
            blpt_pkg::S_AX_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = blpt_pkg::S_AX_EMIT;
                end
            end
            blpt_pkg::S_AX_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_point = 1'b1;
                    o_cmd.step_idx   = 1'b1;
                    n_state = i_stat.idx_last ? blpt_pkg::S_IDLE : blpt_pkg::S_AX_GO;
                end
            end
            default: begin
                n_state = blpt_pkg::S_IDLE;
            end
        endcase
        // The square root is kicked off as the last square is summed.
        o_cmd.root_start = (r_state == blpt_pkg::S_SQ) && i_stat.sq_last;
    end

endmodule

### hdl/blpt_datapath.sv
// Pose stores, bound check, square root, divider use and result register.
module blpt_datapath #(
    parameter int AXES      = blpt_pkg::AXES_DEF,
    parameter int FRAC_BITS = blpt_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  blpt_pkg::t_dp_cmd  i_cmd,
    output blpt_pkg::t_dp_stat o_stat,
    input  logic [1:0]         i_func,
    input  logic [127:0]       i_data,
    input  logic               i_cfg_valid,
    input  logic [30:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [63:0]        o_data,
    output logic               o_kind,
    output logic               o_last
);
    localparam int IW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic signed [33:0] TOL = 34'(((64'sd1 <<< FRAC_BITS) + 50) / 100);
    localparam int NW = blpt_pkg::DIV_NW;
    localparam int DW = blpt_pkg::DIV_DW;

    // Input item fields.
    logic [2:0]         w_axis;
    logic               w_bsel;
    logic signed [31:0] w_bval, w_sval, w_tval;
    logic [7:0]         w_grip;
    logic [15:0]        w_el;
    logic               w_rstmv;
    logic               w_ax_ok;

    assign w_axis  = i_data[2:0];
    assign w_bsel  = i_data[3];
    assign w_bval  = i_data[35:4];
    assign w_sval  = i_data[67:36];
    assign w_tval  = i_data[99:68];
    assign w_grip  = i_data[107:100];
    assign w_el    = i_data[123:108];
    assign w_rstmv = i_data[124];
    assign w_ax_ok = {1'b0, w_axis} < 4'(AXES);

    logic signed [31:0] r_bmin [AXES];
    logic signed [31:0] r_bmax [AXES];
    logic signed [31:0] r_stg_s [AXES];
    logic signed [31:0] r_stg_t [AXES];
    logic signed [31:0] r_act_s [AXES];
    logic signed [31:0] r_act_t [AXES];
    logic [13:0]        r_dur, r_dur_new;
    logic [8:0]         r_pc;
    logic [7:0]         r_goal;
    logic               r_plan_valid;
    logic [30:0]        r_vel;
    logic [15:0]        r_el;
    logic               r_rstmv;
    logic [IW-1:0]      r_idx;
    logic               r_phase;
    logic [65:0]        r_acc;
    logic [8:0]         r_tidx;
    logic [16:0]        r_prog;
    logic signed [31:0] r_pos;
    logic               r_neg;
    blpt_pkg::t_div_sel r_dsel;

    // Divider wiring.
    logic          w_div_busy, w_div_done;
    logic [NW-1:0] w_dividend, w_quot;
    logic [DW-1:0] w_divisor, w_rem;

    // Velocity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel <= 31'(blpt_pkg::tenths(2, FRAC_BITS));
        end else if (i_cfg_valid) begin
            r_vel <= i_cfg_data;
        end
    end

    // Captured item and bound / staged stores.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_bmin[i] <= blpt_pkg::def_bound(i, 1'b0, FRAC_BITS);
                r_bmax[i] <= blpt_pkg::def_bound(i, 1'b1, FRAC_BITS);
            end
            r_goal <= '0;
        end else if (i_cmd.capture) begin
            if (i_func == blpt_pkg::FN_LOAD_BOUND && w_ax_ok) begin
                if (w_bsel) begin
                    r_bmax[w_axis[IW-1:0]] <= w_bval;
                end else begin
                    r_bmin[w_axis[IW-1:0]] <= w_bval;
                end
            end
            if (i_func == blpt_pkg::FN_PLAN) begin
                r_goal <= w_grip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_el    <= w_el;
            r_rstmv <= w_rstmv;
            if (i_func == blpt_pkg::FN_LOAD_AXIS && w_ax_ok) begin
                r_stg_s[w_axis[IW-1:0]] <= w_sval;
                r_stg_t[w_axis[IW-1:0]] <= w_tval;
            end
        end
    end

    // Axis index walks start axes then target axes during the check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_phase <= 1'b0;
        end else if (i_cmd.capture) begin
            r_idx   <= '0;
            r_phase <= 1'b0;
        end else if (i_cmd.step_idx) begin
            if (r_idx == IW'(AXES - 1)) begin
                r_idx   <= '0;
                r_phase <= ~r_phase;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // Bound check of the staged value at the current index.
    logic signed [33:0] w_chk_v, w_chk_min, w_chk_max;
    assign w_chk_v   = 34'(r_phase ? r_stg_t[r_idx] : r_stg_s[r_idx]);
    assign w_chk_min = 34'(r_bmin[r_idx]) - TOL;
    assign w_chk_max = 34'(r_bmax[r_idx]) + TOL;

    // Squared xyz differences, one axis a cycle.
    logic signed [32:0] w_sd;
    logic [32:0]        w_sabs;
    assign w_sd   = 33'(r_stg_t[r_idx]) - 33'(r_stg_s[r_idx]);
    assign w_sabs = w_sd[32] ? 33'(-w_sd) : 33'(w_sd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_acc <= '0;
        end else if (i_cmd.sq_acc) begin
            r_acc <= r_acc + 66'(w_sabs) * 66'(w_sabs);
        end
    end

    // Digit-by-digit square root, two radicand bits a cycle.
    logic [67:0] r_rad;
    logic [37:0] r_rem;
    logic [33:0] r_root;
    logic [5:0]  r_rcnt;
    logic        r_rbusy, r_rdone;
    logic [37:0] w_rtry, w_rtrial;
    logic        w_rge;

    // The radicand enters on the same edge as the last square.
    logic [65:0] w_rad_in;
    assign w_rad_in = r_acc + 66'(w_sabs) * 66'(w_sabs);
    assign w_rtry   = {r_rem[35:0], r_rad[67:66]};
    assign w_rtrial = {2'b00, r_root, 2'b01};
    assign w_rge    = w_rtry >= w_rtrial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rbusy <= 1'b0;
            r_rdone <= 1'b0;
            r_rcnt  <= '0;
        end else begin
            r_rdone <= 1'b0;
            if (i_cmd.root_start) begin
                r_rbusy <= 1'b1;
                r_rcnt  <= 6'd34;
            end else if (r_rbusy) begin
                r_rcnt <= r_rcnt - 1'b1;
                if (r_rcnt == 6'd1) begin
                    r_rbusy <= 1'b0;
                    r_rdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_start) begin
            r_rad  <= {2'b00, w_rad_in};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_rbusy) begin
            r_rad  <= {r_rad[65:0], 2'b00};
            r_rem  <= w_rge ? (w_rtry - w_rtrial) : w_rtry;
            r_root <= {r_root[32:0], w_rge};
        end
    end

    // Operand selection for the shared divider.
    logic signed [32:0] w_ad;
    logic signed [42:0] w_prod;
    logic [NW-1:0]      w_mag;
    assign w_ad   = 33'(r_act_t[r_idx]) - 33'(r_act_s[r_idx]);
    assign w_prod = 43'(w_ad) * 43'($signed({1'b0, r_tidx}));
    assign w_mag  = w_prod[42] ? NW'(-w_prod) : NW'(w_prod);

    always_comb begin
        case (i_cmd.div_sel)
            blpt_pkg::DS_DUR: begin
                w_dividend = NW'(r_root) * NW'(1000);
                w_divisor  = (r_vel == '0) ? DW'(1) : r_vel;
            end
            blpt_pkg::DS_IDX: begin
                w_dividend = NW'(r_el) * NW'(r_pc);
                w_divisor  = DW'(r_dur);
            end
            blpt_pkg::DS_PROG: begin
                w_dividend = NW'({r_el, 16'h0000});
                w_divisor  = DW'(r_dur);
            end
            default: begin
                w_dividend = w_mag;
                w_divisor  = DW'(r_pc);
            end
        endcase
    end

    blpt_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Floor-rounded signed quotient of the axis step.
    logic [NW:0]        w_qmag;
    logic signed [NW:0] w_qs;
    assign w_qmag = {1'b0, w_quot} + (NW+1)'(|w_rem);
    assign w_qs   = r_neg ? -$signed(w_qmag) : $signed({1'b0, w_quot});

    // Results taken from the divider as each division ends.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dsel <= i_cmd.div_sel;
            r_neg  <= w_prod[42];
        end
        if (w_div_done) begin
            case (r_dsel)
                blpt_pkg::DS_DUR: begin
                    if (w_quot < NW'(blpt_pkg::DUR_MIN)) begin
                        r_dur_new <= 14'(blpt_pkg::DUR_MIN);
                    end else if (w_quot > NW'(blpt_pkg::DUR_MAX)) begin
                        r_dur_new <= 14'(blpt_pkg::DUR_MAX);
                    end else begin
                        r_dur_new <= w_quot[13:0];
                    end
                end
                blpt_pkg::DS_IDX: begin
                    r_tidx <= (w_quot > NW'(r_pc)) ? r_pc : w_quot[8:0];
                end
                blpt_pkg::DS_PROG: begin
                    r_prog <= (w_quot > NW'(blpt_pkg::PROG_ONE)) ?
                              17'(blpt_pkg::PROG_ONE) : w_quot[16:0];
                end
                default: begin
                    r_pos <= r_act_s[r_idx] + w_qs[31:0];
                end
            endcase
        end
    end

    // Point count: the duration over 20, as a quarter of it times one fifth.
    logic [24:0] w_pc_prod;
    assign w_pc_prod = 25'(r_dur_new[13:2]) * 25'(blpt_pkg::PT_RECIP);

    // Active trajectory, replaced only by a plan that passed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_act_s[i] <= '0;
                r_act_t[i] <= '0;
            end
            r_dur        <= '0;
            r_pc         <= '0;
            r_plan_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            for (int i = 0; i < AXES; i++) begin
                r_act_s[i] <= r_stg_s[i];
                r_act_t[i] <= r_stg_t[i];
            end
            r_dur        <= r_dur_new;
            r_pc         <= w_pc_prod[blpt_pkg::PT_SHIFT +: 9];
            r_plan_valid <= 1'b1;
        end
    end

    // Gripper command: zero while resetting, else one below the goal once 85 percent of the time has passed.
    logic signed [8:0] w_gcmd;
    logic              w_late;
    assign w_late = (23'(r_el) * 23'd100) >= (23'(r_dur) * 23'd85);
    always_comb begin
        if (r_rstmv) begin
            w_gcmd = '0;
        end else if (w_late) begin
            w_gcmd = $signed({1'b0, r_goal}) - 9'sd1;
        end else begin
            w_gcmd = $signed({1'b0, r_goal});
        end
    end

    // Output register; a new beat may be loaded as the old one is taken.
    logic r_ovalid;
    logic w_out_free;
    assign w_out_free = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_status || i_cmd.emit_point) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_status) begin
            o_data <= {62'd0, i_cmd.status_code};
            o_kind <= blpt_pkg::KIND_STATUS;
            o_last <= 1'b1;
        end else if (i_cmd.emit_point) begin
            o_data <= {1'b0, r_prog, w_gcmd, r_pos, 3'(r_idx), blpt_pkg::ST_OK};
            o_kind <= blpt_pkg::KIND_POINT;
            o_last <= (r_idx == IW'(AXES - 1));
        end
    end

    assign o_valid = r_ovalid;

    // Status back to the controller.
    assign o_stat.idx_last  = (r_idx == IW'(AXES - 1));
    assign o_stat.sq_last   = (r_idx == IW'(2));
    assign o_stat.phase     = r_phase;
    assign o_stat.chk_fail  = (w_chk_v <= w_chk_min) || (w_chk_v >= w_chk_max);
    assign o_stat.root_done = r_rdone;
    assign o_stat.div_done  = w_div_done;
    assign o_stat.out_free  = w_out_free;
    assign o_stat.plan_ok   = r_plan_valid && (r_dur != '0) && (r_pc != '0);

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_status || i_cmd.emit_point) |-> w_out_free)
        else $error("result loaded over a beat not yet taken");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !w_div_busy)
        else $error("divider started while busy");
    a_point_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && o_kind == blpt_pkg::KIND_POINT) |-> r_plan_valid)
        else $error("setpoint beat without a valid plan");
    a_root_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rbusy |-> !w_div_busy)
        else $error("root and divider busy together");
`endif

endmodule

### dv/bounded_linear_pose_trajectory_test.sv
// Self-checking testbench of the bounded linear pose trajectory generator.
`timescale 1ns / 1ps

module bounded_linear_pose_trajectory_test;

    localparam int NAX      = 6;
    localparam int TOL      = 655;            // 0.01 in Q16.16, rounded
    localparam int LIMIT    = 4000000;
    localparam int SETTLE   = 700;
    localparam int VEL_RST  = 13107;

    typedef struct {
        logic [1:0]         func;
        logic [2:0]         axis;
        logic               bsel;
        logic signed [31:0] bval;
        logic signed [31:0] sval;
        logic signed [31:0] tval;
        logic [7:0]         grip;
        logic [15:0]        el;
        logic               rst_move;
    } t_item;

    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic [2:0]         axis;
        logic signed [31:0] pos;
        logic signed [8:0]  grip;
        logic [16:0]        prog;
        logic               last;
    } t_setpoint;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [30:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    bounded_linear_pose_trajectory u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_item     pending_items[$];
    t_setpoint expected_setpoints[$];
    int        send_idle = 6;
    int        recv_idle = 84;
    bit        hold_off  = 1'b0;
    int        mismatches = 0;
    int        beats_seen = 0;
    int        items_sent = 0;
    int        cycles = 0;

    // Shadow state of the trajectory block.
    logic signed [31:0] sh_min[NAX], sh_max[NAX];
    logic signed [31:0] sh_stg_start[NAX], sh_stg_target[NAX];
    logic signed [31:0] sh_act_start[NAX], sh_act_target[NAX];
    longint             sh_duration, sh_points;
    logic [7:0]         sh_grip_goal;
    bit                 sh_valid;
    longint             sh_velocity;

    // Generator view of the bounds, so that well-formed poses can be chosen.
    longint gen_min[NAX], gen_max[NAX];

    function automatic bit pose_fits(logic signed [31:0] p[NAX]);
        for (int i = 0; i < NAX; i++) begin
            if (longint'(p[i]) <= longint'(sh_min[i]) - TOL ||
                longint'(p[i]) >= longint'(sh_max[i]) + TOL) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic longint div_floor(longint n, longint d);
        if (n >= 0) begin
            return n / d;
        end
        return -((-n + d - 1) / d);
    endfunction

    function automatic t_setpoint status_beat(logic [1:0] code);
        t_setpoint r;
        r = '{blpt_pkg::KIND_STATUS, code, 3'd0, 32'sd0, 9'sd0, 17'd0, 1'b1};
        return r;
    endfunction

    // Appends one expected beat at the tail of the queue.
    function automatic void expect_beat(t_setpoint b);
        expected_setpoints.insert(expected_setpoints.size(), b);
    endfunction

    // Works out the result beats of one accepted item and updates the shadow state.
    task automatic predict_trajectory(t_item it);
        logic [67:0] sumsq, root, trial;
        longint      d, dur, vel, idx, prog;
        logic signed [8:0] gcmd;
        t_setpoint   r;
        case (it.func)
            blpt_pkg::FN_LOAD_BOUND: begin
                if (it.axis < NAX) begin
                    if (it.bsel) sh_max[it.axis] = it.bval;
                    else sh_min[it.axis] = it.bval;
                end
            end
            blpt_pkg::FN_LOAD_AXIS: begin
                if (it.axis < NAX) begin
                    sh_stg_start[it.axis] = it.sval;
                    sh_stg_target[it.axis] = it.tval;
                end
            end
            blpt_pkg::FN_PLAN: begin
                sh_grip_goal = it.grip;
                if (!pose_fits(sh_stg_start)) begin
                    expect_beat(status_beat(blpt_pkg::ST_START_OOB));
                end else if (!pose_fits(sh_stg_target)) begin
                    expect_beat(status_beat(blpt_pkg::ST_TGT_OOB));
                end else begin
                    sumsq = '0;
                    for (int i = 0; i < 3; i++) begin
                        d = longint'(sh_stg_target[i]) - longint'(sh_stg_start[i]);
                        if (d < 0) d = -d;
                        sumsq += 68'(d) * 68'(d);
                    end
                    root = '0;
                    for (int b = 33; b >= 0; b--) begin
                        trial = root | (68'd1 << b);
                        if (trial * trial <= sumsq) root = trial;
                    end
                    vel = (sh_velocity == 0) ? 1 : sh_velocity;
                    dur = longint'(root) * 1000 / vel;
                    if (dur < blpt_pkg::DUR_MIN) dur = blpt_pkg::DUR_MIN;
                    if (dur > blpt_pkg::DUR_MAX) dur = blpt_pkg::DUR_MAX;
                    sh_duration = dur;
                    sh_points = dur / blpt_pkg::PT_MS;
                    sh_act_start = sh_stg_start;
                    sh_act_target = sh_stg_target;
                    sh_valid = 1'b1;
                    expect_beat(status_beat(blpt_pkg::ST_OK));
                end
            end
            default: begin
                if (!sh_valid || sh_duration == 0 || sh_points == 0) begin
                    expect_beat(status_beat(blpt_pkg::ST_NO_TRAJ));
                end else begin
                    idx = longint'(it.el) * sh_points / sh_duration;
                    prog = longint'(it.el) * blpt_pkg::PROG_ONE / sh_duration;
                    if (idx > sh_points) idx = sh_points;
                    if (prog > blpt_pkg::PROG_ONE) prog = blpt_pkg::PROG_ONE;
                    if (it.rst_move) gcmd = 9'sd0;
                    else if (longint'(it.el) * 100 >= 85 * sh_duration)
                        gcmd = $signed({1'b0, sh_grip_goal}) - 9'sd1;
                    else gcmd = $signed({1'b0, sh_grip_goal});
                    for (int i = 0; i < NAX; i++) begin
                        d = longint'(sh_act_target[i]) - longint'(sh_act_start[i]);
                        r.kind = blpt_pkg::KIND_POINT;
                        r.status = blpt_pkg::ST_OK;
                        r.axis = 3'(i);
                        r.pos = 32'(longint'(sh_act_start[i]) +
                                    div_floor(d * idx, sh_points));
                        r.grip = gcmd;
                        r.prog = 17'(prog);
                        r.last = (i == NAX - 1);
                        expect_beat(r);
                    end
                end
            end
        endcase
    endtask

    // Input driver: one beat at a time from the pending queue.
    t_item cur_item;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_trajectory(cur_item);
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 && !hold_off &&
                    $urandom_range(99) >= send_idle) begin
                    cur_item = pending_items.pop_front();
                    s_axis_tdata <= {3'b0, cur_item.rst_move, cur_item.el, cur_item.grip,
                                     cur_item.tval, cur_item.sval, cur_item.bval,
                                     cur_item.bsel, cur_item.axis};
                    s_axis_tuser <= cur_item.func;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and back-pressure.
    always @(posedge i_clk) begin
        t_setpoint e, a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_seen++;
            a.kind = m_axis_tuser;
            a.status = m_axis_tdata[1:0];
            a.axis = m_axis_tdata[4:2];
            a.pos = m_axis_tdata[36:5];
            a.grip = m_axis_tdata[45:37];
            a.prog = m_axis_tdata[62:46];
            a.last = m_axis_tlast;
            if (expected_setpoints.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: %p", a);
            end else begin
                e = expected_setpoints.pop_front();
                if (a !== e) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p got %p", e, a);
                end
            end
        end
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_item(logic [1:0] f, logic [2:0] ax, logic bs, longint bv,
                             longint sv, longint tv, logic [7:0] g, logic [15:0] el,
                             logic rm);
        t_item it;
        it = '{f, ax, bs, 32'(bv), 32'(sv), 32'(tv), g, el, rm};
        if (f == blpt_pkg::FN_LOAD_BOUND && ax < NAX) begin
            if (bs) gen_max[ax] = longint'($signed(32'(bv)));
            else gen_min[ax] = longint'($signed(32'(bv)));
        end
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic longint pick_in(int ax);
        longint span;
        span = gen_max[ax] - gen_min[ax];
        if (span <= 0) return gen_min[ax];
        return gen_min[ax] + longint'($urandom) % (span + 1);
    endfunction

    // Optional new bounds, staged axes within them (at times one wild axis), one plan, then up to four ticks.
    task automatic push_motion();
        longint lo, hi;
        if ($urandom_range(3) == 0) begin
            for (int i = 0; i < NAX; i++) begin
                lo = -longint'($urandom_range(200000));
                hi = longint'($urandom_range(200000));
                push_item(blpt_pkg::FN_LOAD_BOUND, 3'(i), 1'b0, lo, 0, 0, 0, 0, 0);
                push_item(blpt_pkg::FN_LOAD_BOUND, 3'(i), 1'b1, hi, 0, 0, 0, 0, 0);
            end
        end
        for (int i = 0; i < NAX; i++) begin
            push_item(blpt_pkg::FN_LOAD_AXIS, 3'(i), 1'b0, 0, pick_in(i), pick_in(i),
                      0, 0, 0);
        end
        if ($urandom_range(5) == 0) begin
            push_item(blpt_pkg::FN_LOAD_AXIS, 3'($urandom_range(NAX - 1)), 1'b0, 0,
                      $urandom, $urandom, 0, 0, 0);
        end
        push_item(blpt_pkg::FN_PLAN, 3'($urandom), 1'($urandom), 0, 0, 0,
                  8'($urandom), 16'($urandom), 1'($urandom));
        repeat ($urandom_range(4)) begin
            push_item(blpt_pkg::FN_TICK, 3'($urandom), 1'($urandom), 0, 0, 0, 8'($urandom),
                      ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(12000)),
                      $urandom_range(5) == 0);
        end
    endtask

    // Noise: ignored axes, wild values, bounds that later motions may replace.
    task automatic push_noise();
        push_item(2'($urandom), 3'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
                  8'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic push_random(int n);
        int start;
        start = pending_items.size();
        while (pending_items.size() - start < n) begin
            if ($urandom_range(9) < 8) push_motion();
            else push_noise();
        end
    endtask

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_items.size() > 0 || s_axis_tvalid || expected_setpoints.size() > 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_velocity(logic [30:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        sh_velocity = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < NAX; i++) begin
            sh_min[i] = blpt_pkg::def_bound(i, 1'b0, blpt_pkg::FRAC_BITS_DEF);
            sh_max[i] = blpt_pkg::def_bound(i, 1'b1, blpt_pkg::FRAC_BITS_DEF);
            gen_min[i] = longint'(sh_min[i]);
            gen_max[i] = longint'(sh_max[i]);
            sh_stg_start[i] = '0;
            sh_stg_target[i] = '0;
            sh_act_start[i] = '0;
            sh_act_target[i] = '0;
        end
        sh_duration = 0;
        sh_points = 0;
        sh_grip_goal = '0;
        sh_valid = 1'b0;
        sh_velocity = VEL_RST;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no trajectory yet, tolerance edges, gripper extremes, tick extremes.
        push_item(blpt_pkg::FN_TICK, 0, 0, 0, 0, 0, 0, 100, 0);
        for (int i = 0; i < NAX; i++) begin
            push_item(blpt_pkg::FN_LOAD_AXIS, 3'(i), 0, 0, gen_min[i] - TOL + 1,
                      gen_max[i] + TOL - 1, 0, 0, 0);
        end
        push_item(blpt_pkg::FN_LOAD_AXIS, 3'd7, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000,
                  0, 0, 0);
        push_item(blpt_pkg::FN_LOAD_BOUND, 3'd6, 1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        push_item(blpt_pkg::FN_PLAN, 0, 0, 0, 0, 0, 8'd0, 0, 0);
        push_item(blpt_pkg::FN_TICK, 0, 0, 0, 0, 0, 0, 16'd0, 0);
        push_item(blpt_pkg::FN_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0);
        push_item(blpt_pkg::FN_LOAD_AXIS, 3'd2, 0, 0, gen_min[2] - TOL, 0, 0, 0, 0);
        push_item(blpt_pkg::FN_PLAN, 0, 0, 0, 0, 0, 8'd255, 0, 0);
        push_item(blpt_pkg::FN_LOAD_AXIS, 3'd2, 0, 0, 0, gen_max[2] + TOL, 0, 0, 0);
        push_item(blpt_pkg::FN_PLAN, 0, 0, 0, 0, 0, 8'd255, 0, 0);
        push_item(blpt_pkg::FN_TICK, 0, 0, 0, 0, 0, 0, 16'd5000, 0);
        push_item(blpt_pkg::FN_TICK, 0, 0, 0, 0, 0, 0, 16'd9000, 1);
        push_item(blpt_pkg::FN_LOAD_AXIS, 3'd2, 0, 0, 0, 0, 0, 0, 0);
        push_item(blpt_pkg::FN_LOAD_BOUND, 3'd0, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
        push_item(blpt_pkg::FN_LOAD_BOUND, 3'd0, 1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
        push_item(blpt_pkg::FN_PLAN, 0, 0, 0, 0, 0, 8'd128, 0, 0);
        push_item(blpt_pkg::FN_TICK, 0, 0, 0, 0, 0, 0, 16'd850, 0);
        push_random(100);

        // Hold the sender until the block has drained once.
        do @(negedge i_clk);
        while (pending_items.size() > 40);
        hold_off = 1'b1;
        do @(negedge i_clk);
        while (s_axis_tvalid || expected_setpoints.size() > 0);
        hold_off = 1'b0;
        wait_quiet();

        write_velocity(31'd1);
        push_random(90);
        wait_quiet();

        send_idle = 84;
        recv_idle = 6;
        write_velocity(31'h7FFF_FFFF);
        push_random(90);
        wait_quiet();

        send_idle = 0;
        recv_idle = 0;
        write_velocity(31'($urandom_range(30000, 1)));
        push_random(90);
        wait_quiet();
        write_velocity(31'($urandom));
        push_random(60);
        wait_quiet();

        $display("Run covered %0d items, %0d result beats, five velocity settings.",
                 items_sent, beats_seen);
        if (mismatches == 0 && expected_setpoints.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
